>>> rtl/swrs_pkg.sv
package swrs_pkg;

  localparam int INT_W      = 64;
  localparam int FLUX_W     = 48;
  localparam int RATIO_BITS = 16;
  localparam int SQ_BITS    = 48;
  localparam int DT_W       = 16;
  localparam logic [DT_W-1:0] DT_RESET = 16'd2621;

  localparam logic [INT_W-1:0] LIM_U = 64'h2000_0000_0000_0000;

  typedef enum logic [4:0] {
    STEP_SQRT_G,
    STEP_SQRT_D,
    STEP_MG,
    STEP_MD,
    STEP_C,
    STEP_T1,
    STEP_FM,
    STEP_A,
    STEP_B,
    STEP_E,
    STEP_F,
    STEP_S2,
    STEP_T2,
    STEP_FQ,
    STEP_DH,
    STEP_DQ,
    STEP_DIV,
    STEP_UNZ,
    STEP_Q,
    STEP_COMMIT
  } step_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_EMIT1,
    S_EMIT2
  } state_t;

  typedef struct packed {
    logic  load_in;
    logic  start;
    step_t step;
    logic  load_out;
    logic  out_end;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic div_ok;
  } dp_status_t;

endpackage

>>> rtl/swrs_ctrl.sv
module swrs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last_cell,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swrs_pkg::dp_cmd_t    cmd,
  input  swrs_pkg::dp_status_t status
);

  swrs_pkg::state_t state_r, state_nxt;
  swrs_pkg::step_t  step_r, step_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             last_r, last_nxt;
  logic             two_r, two_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  function automatic swrs_pkg::step_t next_step(input swrs_pkg::step_t s,
                                                input logic [1:0] fill,
                                                input logic div_ok);
    swrs_pkg::step_t n;
    begin
      unique case (s)
        swrs_pkg::STEP_SQRT_G: n = swrs_pkg::STEP_SQRT_D;
        swrs_pkg::STEP_SQRT_D: n = swrs_pkg::STEP_MG;
        swrs_pkg::STEP_MG:     n = swrs_pkg::STEP_MD;
        swrs_pkg::STEP_MD:     n = swrs_pkg::STEP_C;
        swrs_pkg::STEP_C:      n = swrs_pkg::STEP_T1;
        swrs_pkg::STEP_T1:     n = swrs_pkg::STEP_FM;
        swrs_pkg::STEP_FM:     n = swrs_pkg::STEP_A;
        swrs_pkg::STEP_A:      n = swrs_pkg::STEP_B;
        swrs_pkg::STEP_B:      n = swrs_pkg::STEP_E;
        swrs_pkg::STEP_E:      n = swrs_pkg::STEP_F;
        swrs_pkg::STEP_F:      n = swrs_pkg::STEP_S2;
        swrs_pkg::STEP_S2:     n = swrs_pkg::STEP_T2;
        swrs_pkg::STEP_T2:     n = swrs_pkg::STEP_FQ;
        swrs_pkg::STEP_FQ:     n = fill[1] ? swrs_pkg::STEP_DH : swrs_pkg::STEP_COMMIT;
        swrs_pkg::STEP_DH:     n = swrs_pkg::STEP_DQ;
        swrs_pkg::STEP_DQ:     n = div_ok ? swrs_pkg::STEP_DIV : swrs_pkg::STEP_UNZ;
        swrs_pkg::STEP_DIV:    n = swrs_pkg::STEP_Q;
        swrs_pkg::STEP_UNZ:    n = swrs_pkg::STEP_Q;
        swrs_pkg::STEP_Q:      n = swrs_pkg::STEP_COMMIT;
        default:               n = swrs_pkg::STEP_COMMIT;
      endcase
      return n;
    end
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swrs_pkg::S_IDLE;
      step_r      <= swrs_pkg::STEP_COMMIT;
      fill_r      <= 2'd0;
      last_r      <= 1'b0;
      two_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fill_r      <= fill_nxt;
      last_r      <= last_nxt;
      two_r       <= two_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    fill_nxt  = fill_r;
    last_nxt  = last_r;
    two_nxt   = two_r;
    cmd       = '0;
    cmd.step  = step_r;
    in_stall  = 1'b1;
    unique case (state_r)
      swrs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          last_nxt    = in_last_cell;
          step_nxt    = (fill_r == 2'd0) ? swrs_pkg::STEP_COMMIT : swrs_pkg::STEP_SQRT_G;
          state_nxt   = swrs_pkg::S_ISSUE;
        end
      end
      swrs_pkg::S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = swrs_pkg::S_WAIT;
      end
      swrs_pkg::S_WAIT: begin
        if (status.done) begin
          if (step_r == swrs_pkg::STEP_COMMIT) begin
            if (last_r) begin
              fill_nxt = 2'd0;
            end else if (fill_r == 2'd0) begin
              fill_nxt = 2'd1;
            end else if (fill_r == 2'd1) begin
              fill_nxt = 2'd2;
            end else begin
              fill_nxt = 2'd3;
            end
            two_nxt   = (fill_r == 2'd2) || last_r;
            state_nxt = fill_r[1] ? swrs_pkg::S_EMIT1 : swrs_pkg::S_IDLE;
          end else begin
            step_nxt  = next_step(step_r, fill_r, status.div_ok);
            state_nxt = swrs_pkg::S_ISSUE;
          end
        end
      end
      swrs_pkg::S_EMIT1: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_end  = 1'b0;
          state_nxt    = two_r ? swrs_pkg::S_EMIT2 : swrs_pkg::S_IDLE;
        end
      end
      swrs_pkg::S_EMIT2: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_end  = last_r;
          state_nxt    = swrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swrs_pkg::S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  end

  a_done_not_start: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |-> !cmd.start)
    else $error("unit done while a new step starts");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  a_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swrs_pkg::S_IDLE && in_valid && fill_r == 2'd0)
      |=> (step_r == swrs_pkg::STEP_COMMIT))
    else $error("left ghost not stored directly");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swrs_pkg::S_WAIT && status.done && step_r == swrs_pkg::STEP_COMMIT
     && fill_r[1]) |=> (state_r == swrs_pkg::S_EMIT1))
    else $error("domain cell result skipped");

endmodule

>>> rtl/swrs_dp.sv
module swrs_dp #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [WORD_WIDTH-1:0]  in_depth,
  input  logic signed [WORD_WIDTH-1:0]  in_velocity,
  input  logic                          cfg_wr_en,
  input  logic [swrs_pkg::DT_W-1:0]     cfg_wr_data,
  input  swrs_pkg::dp_cmd_t             cmd,
  output swrs_pkg::dp_status_t          status,
  output logic signed [WORD_WIDTH-1:0]  out_new_depth,
  output logic signed [WORD_WIDTH-1:0]  out_new_velocity,
  output logic signed [WORD_WIDTH-1:0]  out_new_discharge,
  output logic                          out_end_of_sweep
);

  localparam int DIVW     = 62 + FRAC_BITS;
  localparam int CNT_W    = $clog2(DIVW);
  localparam int RAD_W    = 2 * swrs_pkg::SQ_BITS;
  localparam int SQ_REM_W = swrs_pkg::SQ_BITS + 4;
  localparam logic signed [64:0] LIM65 = $signed({1'b0, swrs_pkg::LIM_U});
  localparam logic signed [63:0] LIM64 = $signed(swrs_pkg::LIM_U);
  localparam logic signed [64:0] FMAX  = (65'sd1 <<< (swrs_pkg::FLUX_W - 1)) - 65'sd1;
  localparam logic signed [64:0] WMAX  = (65'sd1 <<< (WORD_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] WMIN  = -WMAX - 65'sd1;
  localparam logic [CNT_W-1:0] CNT_MUL  = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_SQRT = CNT_W'(swrs_pkg::SQ_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_DIV  = CNT_W'(DIVW - 1);

  typedef enum logic [1:0] {K_SIMPLE, K_MUL, K_SQRT, K_DIV} kind_t;

  function automatic logic signed [63:0] sat(input logic signed [64:0] x);
    if (x > LIM65) return LIM64;
    if (x < -LIM65) return -LIM64;
    return x[63:0];
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return sat({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return sat({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] absm(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [64:0] x);
    if (x > FMAX) return FMAX[47:0];
    if (x < -FMAX - 65'sd1) return 48'sh8000_0000_0000;
    return x[47:0];
  endfunction

  function automatic logic signed [WORD_WIDTH-1:0] clampw(input logic signed [63:0] x);
    logic signed [64:0] xe;
    xe = {x[63], x};
    if (xe > WMAX) return WMAX[WORD_WIDTH-1:0];
    if (xe < WMIN) return WMIN[WORD_WIDTH-1:0];
    return xe[WORD_WIDTH-1:0];
  endfunction

  logic signed [63:0] hg_r, ug_r, hd_r, ud_r;
  logic signed [47:0] lmf_r, lqf_r, fm_r, fq_r;
  logic [swrs_pkg::DT_W-1:0] dt_r;
  logic [swrs_pkg::SQ_BITS-1:0] sg_r, sd_r;
  logic signed [63:0] c_r, mg_r, md_r, t1_r, a_r, b_r, e_r, f_r, s2_r, t2_r;
  logic signed [63:0] hn_r, num_r, un_r, q_r;

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r, last_cnt;
  kind_t             kind_r, kind;
  swrs_pkg::step_t   cur_r;
  logic              done;

  logic [63:0]  ma_r, mb_r;
  logic         mneg_r, msh16_r;
  logic [127:0] macc_r, macc_nxt, mshift;
  logic [63:0]  pp, mmag;
  logic [1:0]   psum;
  logic signed [63:0] mres;

  logic [RAD_W-1:0]    srad_r;
  logic [SQ_REM_W-1:0] srem_r, srem_sh, strial, srem_nxt;
  logic [swrs_pkg::SQ_BITS-1:0] sroot_r, sroot_nxt;
  logic                sge;

  logic [DIVW-1:0] dnum_r, dq_r, dq_nxt;
  logic [62:0]     drem_r, drem_sh, drem_nxt;
  logic [61:0]     dd_r;
  logic            dneg_r, dge;
  logic [63:0]     dmag;
  logic signed [63:0] dres;

  logic signed [63:0] op_a, op_b, sq_x, dfm, dfq;
  logic               op_sh16;
  logic signed [63:0] cg, cd, fm_pre, fq_pre;
  logic [63:0]        nmag;

  assign dfm = 64'(lmf_r) - 64'(fm_r) == 64'sd0 ? 64'sd0 : 64'(fm_r) - 64'(lmf_r);
  assign dfq = 64'(fq_r) - 64'(lqf_r);

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_sh16 = 1'b0;
    unique case (cmd.step)
      swrs_pkg::STEP_SQRT_G, swrs_pkg::STEP_SQRT_D: kind = K_SQRT;
      swrs_pkg::STEP_DIV: kind = K_DIV;
      swrs_pkg::STEP_MG: begin kind = K_MUL; op_a = hg_r; op_b = ug_r; end
      swrs_pkg::STEP_MD: begin kind = K_MUL; op_a = hd_r; op_b = ud_r; end
      swrs_pkg::STEP_T1: begin kind = K_MUL; op_a = c_r; op_b = ssub(hd_r, hg_r); end
      swrs_pkg::STEP_A:  begin kind = K_MUL; op_a = ug_r; op_b = mg_r; end
      swrs_pkg::STEP_B:  begin kind = K_MUL; op_a = hg_r; op_b = hg_r; end
      swrs_pkg::STEP_E:  begin kind = K_MUL; op_a = ud_r; op_b = md_r; end
      swrs_pkg::STEP_F:  begin kind = K_MUL; op_a = hd_r; op_b = hd_r; end
      swrs_pkg::STEP_T2: begin kind = K_MUL; op_a = c_r; op_b = ssub(md_r, mg_r); end
      swrs_pkg::STEP_DH: begin
        kind = K_MUL; op_a = $signed(64'(dt_r)); op_b = dfm; op_sh16 = 1'b1;
      end
      swrs_pkg::STEP_DQ: begin
        kind = K_MUL; op_a = $signed(64'(dt_r)); op_b = dfq; op_sh16 = 1'b1;
      end
      swrs_pkg::STEP_Q:  begin kind = K_MUL; op_a = hn_r; op_b = un_r; end
      default: kind = K_SIMPLE;
    endcase
    sq_x = (cmd.step == swrs_pkg::STEP_SQRT_G) ? hg_r : hd_r;
    nmag = absm(num_r);
  end

  always_comb begin
    unique case (kind_r)
      K_MUL:   last_cnt = CNT_MUL;
      K_SQRT:  last_cnt = CNT_SQRT;
      K_DIV:   last_cnt = CNT_DIV;
      default: last_cnt = '0;
    endcase
  end

  assign done          = busy_r && (cnt_r == last_cnt);
  assign status.done   = done;
  assign status.div_ok = (hg_r > 64'sd0) && (hn_r > 64'sd0);

  // multiply: one 32x32 partial product per cycle
  assign pp       = 64'(ma_r[{cnt_r[1], 5'd0} +: 32]) * 64'(mb_r[{cnt_r[0], 5'd0} +: 32]);
  assign psum     = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
  assign macc_nxt = macc_r + (128'(pp) << {psum, 5'd0});
  assign mshift   = msh16_r ? (macc_nxt >> swrs_pkg::RATIO_BITS) : (macc_nxt >> FRAC_BITS);
  assign mmag     = (mshift > 128'(swrs_pkg::LIM_U)) ? swrs_pkg::LIM_U : mshift[63:0];
  assign mres     = mneg_r ? -$signed(mmag) : $signed(mmag);

  // square root: two radicand bits per cycle
  assign srem_sh   = {srem_r[SQ_REM_W-3:0], srad_r[RAD_W-1 -: 2]};
  assign strial    = SQ_REM_W'({sroot_r, 2'b01});
  assign sge       = srem_sh >= strial;
  assign srem_nxt  = sge ? srem_sh - strial : srem_sh;
  assign sroot_nxt = {sroot_r[swrs_pkg::SQ_BITS-2:0], sge};

  // divide: one quotient bit per cycle
  assign drem_sh  = {drem_r[61:0], dnum_r[DIVW-1]};
  assign dge      = drem_sh >= 63'(dd_r);
  assign drem_nxt = dge ? drem_sh - 63'(dd_r) : drem_sh;
  assign dq_nxt   = {dq_r[DIVW-2:0], dge};
  assign dmag     = (dq_nxt > DIVW'(swrs_pkg::LIM_U)) ? swrs_pkg::LIM_U : dq_nxt[63:0];
  assign dres     = dneg_r ? -$signed(dmag) : $signed(dmag);

  assign cg     = sadd($signed(absm(ug_r)), $signed(64'(sg_r)));
  assign cd     = sadd($signed(absm(ud_r)), $signed(64'(sd_r)));
  assign fm_pre = sadd(mg_r, md_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      dt_r   <= swrs_pkg::DT_RESET;
      hg_r   <= '0;
      ug_r   <= '0;
      lmf_r  <= '0;
      lqf_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        dt_r <= cfg_wr_data;
      end
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (done && cur_r == swrs_pkg::STEP_COMMIT) begin
        hg_r  <= hd_r;
        ug_r  <= ud_r;
        lmf_r <= fm_r;
        lqf_r <= fq_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hd_r <= sat(65'($signed(in_depth)));
      ud_r <= sat(65'($signed(in_velocity)));
    end
    if (cmd.start) begin
      cur_r   <= cmd.step;
      kind_r  <= kind;
      ma_r    <= absm(op_a);
      mb_r    <= absm(op_b);
      mneg_r  <= op_a[63] ^ op_b[63];
      msh16_r <= op_sh16;
      macc_r  <= '0;
      srad_r  <= (sq_x > 64'sd0) ? (RAD_W'(sq_x[62:0]) << FRAC_BITS) : '0;
      srem_r  <= '0;
      sroot_r <= '0;
      dnum_r  <= {nmag[61:0], {FRAC_BITS{1'b0}}};
      dneg_r  <= num_r[63];
      dd_r    <= hn_r[61:0];
      drem_r  <= '0;
      dq_r    <= '0;
    end else if (busy_r) begin
      macc_r  <= macc_nxt;
      srad_r  <= srad_r << 2;
      srem_r  <= srem_nxt;
      sroot_r <= sroot_nxt;
      dnum_r  <= dnum_r << 1;
      drem_r  <= drem_nxt[61:0];
      dq_r    <= dq_nxt;
    end
    if (done) begin
      unique case (cur_r)
        swrs_pkg::STEP_SQRT_G: sg_r <= sroot_nxt;
        swrs_pkg::STEP_SQRT_D: sd_r <= sroot_nxt;
        swrs_pkg::STEP_MG:     mg_r <= mres;
        swrs_pkg::STEP_MD:     md_r <= mres;
        swrs_pkg::STEP_C:      c_r  <= (cg > cd) ? cg : cd;
        swrs_pkg::STEP_T1:     t1_r <= mres;
        swrs_pkg::STEP_FM:
          fm_r <= clamp48($signed({fm_pre[63], fm_pre} - {t1_r[63], t1_r}) >>> 1);
        swrs_pkg::STEP_A:      a_r  <= mres;
        swrs_pkg::STEP_B:      b_r  <= mres >>> 1;
        swrs_pkg::STEP_E:      e_r  <= mres;
        swrs_pkg::STEP_F:      f_r  <= mres >>> 1;
        swrs_pkg::STEP_S2:     s2_r <= sadd(sadd(a_r, b_r), sadd(e_r, f_r));
        swrs_pkg::STEP_T2:     t2_r <= mres;
        swrs_pkg::STEP_FQ:
          fq_r <= clamp48($signed({fq_pre[63], fq_pre} - {t2_r[63], t2_r}) >>> 1);
        swrs_pkg::STEP_DH:     hn_r <= ssub(hg_r, mres);
        swrs_pkg::STEP_DQ:     num_r <= ssub(mg_r, mres);
        swrs_pkg::STEP_DIV:    un_r <= dres;
        swrs_pkg::STEP_UNZ:    un_r <= '0;
        swrs_pkg::STEP_Q:      q_r  <= mres;
        default: begin
        end
      endcase
    end
    if (cmd.load_out) begin
      out_new_depth     <= clampw(hn_r);
      out_new_velocity  <= clampw(un_r);
      out_new_discharge <= clampw(q_r);
      out_end_of_sweep  <= cmd.out_end;
    end
  end

  assign fq_pre = s2_r;

  a_fq_src: assert property (@(posedge clk) disable iff (!rst_n)
    (done && cur_r == swrs_pkg::STEP_DIV) |-> (hn_r > 64'sd0))
    else $error("divide by non-positive depth");

  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r || done)
    else $error("step started while unit busy");

  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !cmd.start) |=> !busy_r)
    else $error("unit stays busy after finishing");

  a_fq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !done) |=> $stable(cur_r))
    else $error("step changed mid operation");

endmodule

>>> rtl/shallow_water_rusanov_sweep_core.sv
// One explicit shallow water time step with a Rusanov flux, streamed cell by
// cell over a sweep (left ghost, domain cells, right ghost marked by
// in_last_cell). Each request is taken only while the core is idle; a domain
// cell occupies one shared multiply (four 32x32 partial products), square root
// (one root bit per cycle) and divide (one quotient bit per cycle) unit in
// turn, the divide only when the old and new depths are positive. The left
// ghost is only stored, not computed. The result register lets the next
// request enter while a result waits on out_stall. dt_over_dx is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while idle, as
// the core itself does not enforce this. It resets to 2621.
module shallow_water_rusanov_sweep_core #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [WORD_WIDTH-1:0]  in_depth,
  input  logic signed [WORD_WIDTH-1:0]  in_velocity,
  input  logic                          in_last_cell,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [WORD_WIDTH-1:0]  out_new_depth,
  output logic signed [WORD_WIDTH-1:0]  out_new_velocity,
  output logic signed [WORD_WIDTH-1:0]  out_new_discharge,
  output logic                          out_end_of_sweep,
  input  logic                          cfg_wr_en,
  input  logic [swrs_pkg::DT_W-1:0]     cfg_wr_data
);

  swrs_pkg::dp_cmd_t    cmd;
  swrs_pkg::dp_status_t status;

  swrs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_cell (in_last_cell),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status)
  );

  swrs_dp #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_depth          (in_depth),
    .in_velocity       (in_velocity),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .cmd               (cmd),
    .status            (status),
    .out_new_depth     (out_new_depth),
    .out_new_velocity  (out_new_velocity),
    .out_new_discharge (out_new_discharge),
    .out_end_of_sweep  (out_end_of_sweep)
  );

endmodule
